// ===== hdl/cpu8_pkg.sv =====
// ============================================================================
// cpu8_pkg
// Shared operation codes, status flag positions and field widths for the
// 8-bit accumulator-machine execute block.
// ============================================================================
package cpu8_pkg;

    localparam int unsigned OP_W   = 6;
    localparam int unsigned BYTE_W = 8;

    // Status byte bit positions
    localparam int unsigned FLAG_C = 0;
    localparam int unsigned FLAG_Z = 1;
    localparam int unsigned FLAG_I = 2;
    localparam int unsigned FLAG_D = 3;
    localparam int unsigned FLAG_V = 6;
    localparam int unsigned FLAG_N = 7;

    typedef enum logic [OP_W-1:0] {
        OP_ORA = 6'd0,
        OP_AND = 6'd1,
        OP_EOR = 6'd2,
        OP_ADC = 6'd3,
        OP_SBC = 6'd4,
        OP_STA = 6'd5,
        OP_STX = 6'd6,
        OP_STY = 6'd7,
        OP_LDA = 6'd8,
        OP_LDX = 6'd9,
        OP_LDY = 6'd10,
        OP_INC = 6'd11,
        OP_INX = 6'd12,
        OP_INY = 6'd13,
        OP_DEC = 6'd14,
        OP_DEX = 6'd15,
        OP_DEY = 6'd16,
        OP_CMP = 6'd17,
        OP_CPX = 6'd18,
        OP_CPY = 6'd19,
        OP_BIT = 6'd20,
        OP_ASL = 6'd21,
        OP_LSR = 6'd22,
        OP_ROL = 6'd23,
        OP_ROR = 6'd24,
        OP_TAX = 6'd25,
        OP_TAY = 6'd26,
        OP_TXA = 6'd27,
        OP_TYA = 6'd28,
        OP_TSX = 6'd29,
        OP_TXS = 6'd30,
        OP_CLC = 6'd31,
        OP_CLD = 6'd32,
        OP_CLI = 6'd33,
        OP_CLV = 6'd34,
        OP_SEC = 6'd35,
        OP_SED = 6'd36,
        OP_SEI = 6'd37,
        OP_NOP = 6'd38
    } op_t;

endpackage

// ===== hdl/cpu8_req_if.sv =====
// ============================================================================
// cpu8_req_if
// Request channel: one operation item with its fetched operand byte.
// ============================================================================
interface cpu8_req_if;

    logic                              valid;
    logic                              ready;
    logic [cpu8_pkg::OP_W-1:0]         req_type;
    logic [cpu8_pkg::BYTE_W-1:0]       operand;
    logic                              to_accumulator;

    modport source (output valid, output req_type, output operand,
                    output to_accumulator, input ready);
    modport sink   (input valid, input req_type, input operand,
                    input to_accumulator, output ready);

endinterface

// ===== hdl/cpu8_rsp_if.sv =====
// ============================================================================
// cpu8_rsp_if
// Result channel: registers, status and memory write-back for one item.
// ============================================================================
interface cpu8_rsp_if;

    logic                              valid;
    logic                              ready;
    logic [cpu8_pkg::BYTE_W-1:0]       acc_out;
    logic [cpu8_pkg::BYTE_W-1:0]       x_out;
    logic [cpu8_pkg::BYTE_W-1:0]       y_out;
    logic [cpu8_pkg::BYTE_W-1:0]       status_out;
    logic                              write_back;
    logic [cpu8_pkg::BYTE_W-1:0]       store_value;
    logic                              decimal_error;

    modport source (output valid, output acc_out, output x_out, output y_out,
                    output status_out, output write_back, output store_value,
                    output decimal_error, input ready);
    modport sink   (input valid, input acc_out, input x_out, input y_out,
                    input status_out, input write_back, input store_value,
                    input decimal_error, output ready);

endinterface

// ===== hdl/cpu8_alu_register_execute_top.sv =====
// Stages: input register, then result register; the execute logic is one
//   8-bit adder/logic/flag path. Throughput: one item per cycle unless rsp
//   stalls; while a result waits, only an empty input register takes one.
// Reset: rst_n asynchronously clears A, X, Y, S, status and both valid bits.
// ============================================================================
// cpu8_alu_register_execute_top
// Binary-mode execute stage of an 8-bit accumulator CPU: holds A, X, Y, S
// and the status byte, executes one operation per item and returns the
// updated registers plus any memory write-back byte.
// ============================================================================
module cpu8_alu_register_execute_top
(
    input  logic             clk,
    input  logic             rst_n,
    cpu8_req_if.sink         req,
    cpu8_rsp_if.source       rsp
);

    localparam int unsigned BW = cpu8_pkg::BYTE_W;

    // ------------------------------------------------------------------
    // Input register stage
    // ------------------------------------------------------------------
    logic                          in_valid_reg;
    logic [cpu8_pkg::OP_W-1:0]     in_type_reg;
    logic [BW-1:0]                 in_operand_reg;
    logic                          in_to_acc_reg;

    // ------------------------------------------------------------------
    // Architectural registers
    // ------------------------------------------------------------------
    logic [BW-1:0] acc_reg,    acc_next;
    logic [BW-1:0] x_reg,      x_next;
    logic [BW-1:0] y_reg,      y_next;
    logic [BW-1:0] sp_reg,     sp_next;
    logic [BW-1:0] status_reg, status_next;

    // ------------------------------------------------------------------
    // Result register stage
    // ------------------------------------------------------------------
    logic          out_valid_reg;
    logic [BW-1:0] out_acc_reg;
    logic [BW-1:0] out_x_reg;
    logic [BW-1:0] out_y_reg;
    logic [BW-1:0] out_status_reg;
    logic          out_wb_reg;
    logic [BW-1:0] out_sv_reg;
    logic          out_derr_reg;

    // Execute results
    logic          wb_next;
    logic [BW-1:0] sv_next;
    logic          derr_next;

    // The result register advances when empty or being drained; the input
    // register advances whenever its item moves into the result register.
    logic advance;
    logic execute;

    assign advance   = !out_valid_reg || rsp.ready;
    assign execute   = in_valid_reg && advance;
    assign req.ready = !in_valid_reg || advance;

    // ------------------------------------------------------------------
    // Execute logic: one pass against the current architectural state
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [BW:0]   sum;
        logic [BW-1:0] addend;
        logic [BW-1:0] cmp_reg;
        logic [BW:0]   diff;
        logic [BW-1:0] shv;
        logic [BW-1:0] shr;
        logic          cin;
        logic          set_nz;
        logic [BW-1:0] nz_val;

        acc_next    = acc_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        sp_next     = sp_reg;
        status_next = status_reg;
        wb_next     = 1'b0;
        sv_next     = '0;
        derr_next   = 1'b0;
        set_nz      = 1'b0;
        nz_val      = '0;

        cin = status_reg[cpu8_pkg::FLAG_C];

        // Shared adder for ADC / SBC (SBC adds the inverted operand)
        addend = (in_type_reg == cpu8_pkg::OP_SBC) ? ~in_operand_reg : in_operand_reg;
        sum    = {1'b0, acc_reg} + {1'b0, addend} + {{BW{1'b0}}, cin};

        // Shared subtractor for compares
        case (in_type_reg)
            cpu8_pkg::OP_CPX: cmp_reg = x_reg;
            cpu8_pkg::OP_CPY: cmp_reg = y_reg;
            default:          cmp_reg = acc_reg;
        endcase
        diff = {1'b0, cmp_reg} - {1'b0, in_operand_reg};

        // Shifter source and result
        shv = in_to_acc_reg ? acc_reg : in_operand_reg;
        case (in_type_reg)
            cpu8_pkg::OP_ASL: shr = {shv[BW-2:0], 1'b0};
            cpu8_pkg::OP_ROL: shr = {shv[BW-2:0], cin};
            cpu8_pkg::OP_LSR: shr = {1'b0, shv[BW-1:1]};
            cpu8_pkg::OP_ROR: shr = {cin, shv[BW-1:1]};
            default:          shr = shv;
        endcase

        case (in_type_reg)
            cpu8_pkg::OP_ORA:
            begin
                acc_next = acc_reg | in_operand_reg;
                set_nz   = 1'b1;
                nz_val   = acc_next;
            end
            cpu8_pkg::OP_AND:
            begin
                acc_next = acc_reg & in_operand_reg;
                set_nz   = 1'b1;
                nz_val   = acc_next;
            end
            cpu8_pkg::OP_EOR:
            begin
                acc_next = acc_reg ^ in_operand_reg;
                set_nz   = 1'b1;
                nz_val   = acc_next;
            end
            cpu8_pkg::OP_ADC, cpu8_pkg::OP_SBC:
            begin
                // Decimal mode is refused: hold all state, flag the error
                if (status_reg[cpu8_pkg::FLAG_D])
                begin
                    derr_next = 1'b1;
                end
                else
                begin
                    acc_next = sum[BW-1:0];
                    status_next[cpu8_pkg::FLAG_C] = sum[BW];
                    status_next[cpu8_pkg::FLAG_V] = ~(acc_reg[BW-1] ^ addend[BW-1])
                                                    & (acc_reg[BW-1] ^ sum[BW-1]);
                    set_nz = 1'b1;
                    nz_val = sum[BW-1:0];
                end
            end
            cpu8_pkg::OP_STA:
            begin
                wb_next = 1'b1;
                sv_next = acc_reg;
            end
            cpu8_pkg::OP_STX:
            begin
                wb_next = 1'b1;
                sv_next = x_reg;
            end
            cpu8_pkg::OP_STY:
            begin
                wb_next = 1'b1;
                sv_next = y_reg;
            end
            cpu8_pkg::OP_LDA:
            begin
                acc_next = in_operand_reg;
                set_nz   = 1'b1;
                nz_val   = in_operand_reg;
            end
            cpu8_pkg::OP_LDX:
            begin
                x_next = in_operand_reg;
                set_nz = 1'b1;
                nz_val = in_operand_reg;
            end
            cpu8_pkg::OP_LDY:
            begin
                y_next = in_operand_reg;
                set_nz = 1'b1;
                nz_val = in_operand_reg;
            end
            cpu8_pkg::OP_INC:
            begin
                wb_next = 1'b1;
                sv_next = in_operand_reg + BW'(1);
                set_nz  = 1'b1;
                nz_val  = sv_next;
            end
            cpu8_pkg::OP_INX:
            begin
                x_next = x_reg + BW'(1);
                set_nz = 1'b1;
                nz_val = x_next;
            end
            cpu8_pkg::OP_INY:
            begin
                y_next = y_reg + BW'(1);
                set_nz = 1'b1;
                nz_val = y_next;
            end
            cpu8_pkg::OP_DEC:
            begin
                wb_next = 1'b1;
                sv_next = in_operand_reg - BW'(1);
                set_nz  = 1'b1;
                nz_val  = sv_next;
            end
            cpu8_pkg::OP_DEX:
            begin
                x_next = x_reg - BW'(1);
                set_nz = 1'b1;
                nz_val = x_next;
            end
            cpu8_pkg::OP_DEY:
            begin
                y_next = y_reg - BW'(1);
                set_nz = 1'b1;
                nz_val = y_next;
            end
            cpu8_pkg::OP_CMP, cpu8_pkg::OP_CPX, cpu8_pkg::OP_CPY:
            begin
                // Carry means no borrow: register >= operand
                status_next[cpu8_pkg::FLAG_N] = diff[BW-1];
                status_next[cpu8_pkg::FLAG_Z] = (cmp_reg == in_operand_reg);
                status_next[cpu8_pkg::FLAG_C] = ~diff[BW];
            end
            cpu8_pkg::OP_BIT:
            begin
                status_next[cpu8_pkg::FLAG_N] = in_operand_reg[BW-1];
                status_next[cpu8_pkg::FLAG_V] = in_operand_reg[BW-2];
                status_next[cpu8_pkg::FLAG_Z] = ((in_operand_reg & acc_reg) == '0);
            end
            cpu8_pkg::OP_ASL, cpu8_pkg::OP_ROL:
            begin
                status_next[cpu8_pkg::FLAG_C] = shv[BW-1];
                set_nz = 1'b1;
                nz_val = shr;
                if (in_to_acc_reg)
                begin
                    acc_next = shr;
                end
                else
                begin
                    wb_next = 1'b1;
                    sv_next = shr;
                end
            end
            cpu8_pkg::OP_LSR, cpu8_pkg::OP_ROR:
            begin
                status_next[cpu8_pkg::FLAG_C] = shv[0];
                set_nz = 1'b1;
                nz_val = shr;
                if (in_to_acc_reg)
                begin
                    acc_next = shr;
                end
                else
                begin
                    wb_next = 1'b1;
                    sv_next = shr;
                end
            end
            cpu8_pkg::OP_TAX:
            begin
                x_next = acc_reg;
                set_nz = 1'b1;
                nz_val = acc_reg;
            end
            cpu8_pkg::OP_TAY:
            begin
                y_next = acc_reg;
                set_nz = 1'b1;
                nz_val = acc_reg;
            end
            cpu8_pkg::OP_TXA:
            begin
                acc_next = x_reg;
                set_nz   = 1'b1;
                nz_val   = x_reg;
            end
            cpu8_pkg::OP_TYA:
            begin
                acc_next = y_reg;
                set_nz   = 1'b1;
                nz_val   = y_reg;
            end
            cpu8_pkg::OP_TSX:
            begin
                x_next = sp_reg;
                set_nz = 1'b1;
                nz_val = sp_reg;
            end
            cpu8_pkg::OP_TXS: sp_next = x_reg;   // no flags touched
            cpu8_pkg::OP_CLC: status_next[cpu8_pkg::FLAG_C] = 1'b0;
            cpu8_pkg::OP_CLD: status_next[cpu8_pkg::FLAG_D] = 1'b0;
            cpu8_pkg::OP_CLI: status_next[cpu8_pkg::FLAG_I] = 1'b0;
            cpu8_pkg::OP_CLV: status_next[cpu8_pkg::FLAG_V] = 1'b0;
            cpu8_pkg::OP_SEC: status_next[cpu8_pkg::FLAG_C] = 1'b1;
            cpu8_pkg::OP_SED: status_next[cpu8_pkg::FLAG_D] = 1'b1;
            cpu8_pkg::OP_SEI: status_next[cpu8_pkg::FLAG_I] = 1'b1;
            default:
            begin
                // NOP and undefined codes: leave everything unchanged
            end
        endcase

        if (set_nz)
        begin
            status_next[cpu8_pkg::FLAG_N] = nz_val[BW-1];
            status_next[cpu8_pkg::FLAG_Z] = (nz_val == '0);
        end
    end

    // ------------------------------------------------------------------
    // Input register: capture a new item whenever the stage frees up
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            in_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_type_reg    <= req.req_type;
            in_operand_reg <= req.operand;
            in_to_acc_reg  <= req.to_accumulator;
        end
    end

    // ------------------------------------------------------------------
    // Architectural state: commit when the item moves to the result stage
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg    <= '0;
            x_reg      <= '0;
            y_reg      <= '0;
            sp_reg     <= '0;
            status_reg <= '0;
        end
        else if (execute)
        begin
            acc_reg    <= acc_next;
            x_reg      <= x_next;
            y_reg      <= y_next;
            sp_reg     <= sp_next;
            status_reg <= status_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register: hold while stalled, advance otherwise
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (execute)
        begin
            out_acc_reg    <= acc_next;
            out_x_reg      <= x_next;
            out_y_reg      <= y_next;
            out_status_reg <= status_next;
            out_wb_reg     <= wb_next;
            out_sv_reg     <= sv_next;
            out_derr_reg   <= derr_next;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.acc_out       = out_acc_reg;
    assign rsp.x_out         = out_x_reg;
    assign rsp.y_out         = out_y_reg;
    assign rsp.status_out    = out_status_reg;
    assign rsp.write_back    = out_wb_reg;
    assign rsp.store_value   = out_sv_reg;
    assign rsp.decimal_error = out_derr_reg;

endmodule

// ===== tb/sv/cpu8_exec_mirror_pkg.sv =====
// ============================================================================
// cpu8_exec_mirror_pkg
// Register mirror of the binary-mode execute stage: predicts A, X, Y, S and
// the status byte for each accepted item and checks the returned results.
// ============================================================================
package cpu8_exec_mirror_pkg;

    import cpu8_pkg::*;

    typedef struct packed {
        logic [BYTE_W-1:0] acc;
        logic [BYTE_W-1:0] x;
        logic [BYTE_W-1:0] y;
        logic [BYTE_W-1:0] status;
        logic              write_back;
        logic [BYTE_W-1:0] store_value;
        logic              decimal_error;
    } exec_result_t;

    class cpu8_exec_mirror;

        logic [BYTE_W-1:0] acc_q;
        logic [BYTE_W-1:0] x_q;
        logic [BYTE_W-1:0] y_q;
        logic [BYTE_W-1:0] sp_q;
        logic [BYTE_W-1:0] flags_q;
        exec_result_t      expected_q[$];
        int unsigned       mismatch_count;

        function new();
            acc_q          = '0;
            x_q            = '0;
            y_q            = '0;
            sp_q           = '0;
            flags_q        = '0;
            mismatch_count = 0;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function void set_nz(logic [BYTE_W-1:0] v);
            flags_q[FLAG_N] = v[7];
            flags_q[FLAG_Z] = (v == '0);
        endfunction

        function void compare_with(logic [BYTE_W-1:0] reg_val, logic [BYTE_W-1:0] m);
            logic [BYTE_W-1:0] diff;
            diff = reg_val - m;
            flags_q[FLAG_N] = diff[7];
            flags_q[FLAG_Z] = (reg_val == m);
            flags_q[FLAG_C] = (reg_val >= m);
        endfunction

        // Advance the mirrored registers by one item and queue its result.
        function void note_op(logic [OP_W-1:0] code, logic [BYTE_W-1:0] m, logic to_acc);
            exec_result_t      res;
            logic [BYTE_W-1:0] v;
            logic [BYTE_W-1:0] r;
            logic [BYTE_W-1:0] b;
            logic [BYTE_W:0]   sum;
            res.write_back    = 1'b0;
            res.store_value   = '0;
            res.decimal_error = 1'b0;
            case (code)
                OP_ASL, OP_LSR, OP_ROL, OP_ROR:
                begin
                    v = to_acc ? acc_q : m;
                    case (code)
                        OP_ASL:  r = {v[6:0], 1'b0};
                        OP_ROL:  r = {v[6:0], flags_q[FLAG_C]};
                        OP_LSR:  r = {1'b0, v[7:1]};
                        default: r = {flags_q[FLAG_C], v[7:1]};
                    endcase
                    flags_q[FLAG_C] = (code == OP_ASL || code == OP_ROL) ? v[7] : v[0];
                    if (to_acc)
                    begin
                        acc_q = r;
                    end
                    else
                    begin
                        res.write_back  = 1'b1;
                        res.store_value = r;
                    end
                    set_nz(r);
                end
                OP_ORA: begin acc_q = acc_q | m; set_nz(acc_q); end
                OP_AND: begin acc_q = acc_q & m; set_nz(acc_q); end
                OP_EOR: begin acc_q = acc_q ^ m; set_nz(acc_q); end
                OP_ADC, OP_SBC:
                begin
                    // Refuse decimal mode: nothing changes but the error bit.
                    if (flags_q[FLAG_D])
                    begin
                        res.decimal_error = 1'b1;
                    end
                    else
                    begin
                        b   = (code == OP_ADC) ? m : ~m;
                        sum = {1'b0, acc_q} + {1'b0, b} + {{BYTE_W{1'b0}}, flags_q[FLAG_C]};
                        r   = sum[BYTE_W-1:0];
                        flags_q[FLAG_C] = sum[BYTE_W];
                        flags_q[FLAG_V] = ~(acc_q[7] ^ b[7]) & (acc_q[7] ^ r[7]);
                        acc_q = r;
                        set_nz(r);
                    end
                end
                OP_STA: begin res.write_back = 1'b1; res.store_value = acc_q; end
                OP_STX: begin res.write_back = 1'b1; res.store_value = x_q; end
                OP_STY: begin res.write_back = 1'b1; res.store_value = y_q; end
                OP_LDA: begin acc_q = m; set_nz(m); end
                OP_LDX: begin x_q = m; set_nz(m); end
                OP_LDY: begin y_q = m; set_nz(m); end
                OP_INC:
                begin
                    res.write_back  = 1'b1;
                    res.store_value = m + 8'd1;
                    set_nz(res.store_value);
                end
                OP_DEC:
                begin
                    res.write_back  = 1'b1;
                    res.store_value = m - 8'd1;
                    set_nz(res.store_value);
                end
                OP_INX: begin x_q = x_q + 8'd1; set_nz(x_q); end
                OP_INY: begin y_q = y_q + 8'd1; set_nz(y_q); end
                OP_DEX: begin x_q = x_q - 8'd1; set_nz(x_q); end
                OP_DEY: begin y_q = y_q - 8'd1; set_nz(y_q); end
                OP_CMP: compare_with(acc_q, m);
                OP_CPX: compare_with(x_q, m);
                OP_CPY: compare_with(y_q, m);
                OP_BIT:
                begin
                    flags_q[FLAG_N] = m[7];
                    flags_q[FLAG_V] = m[6];
                    flags_q[FLAG_Z] = ((m & acc_q) == '0);
                end
                OP_TAX: begin x_q = acc_q; set_nz(x_q); end
                OP_TAY: begin y_q = acc_q; set_nz(y_q); end
                OP_TXA: begin acc_q = x_q; set_nz(acc_q); end
                OP_TYA: begin acc_q = y_q; set_nz(acc_q); end
                OP_TSX: begin x_q = sp_q; set_nz(x_q); end
                OP_TXS: sp_q = x_q;
                OP_CLC: flags_q[FLAG_C] = 1'b0;
                OP_CLD: flags_q[FLAG_D] = 1'b0;
                OP_CLI: flags_q[FLAG_I] = 1'b0;
                OP_CLV: flags_q[FLAG_V] = 1'b0;
                OP_SEC: flags_q[FLAG_C] = 1'b1;
                OP_SED: flags_q[FLAG_D] = 1'b1;
                OP_SEI: flags_q[FLAG_I] = 1'b1;
                default: ;
            endcase
            res.acc    = acc_q;
            res.x      = x_q;
            res.y      = y_q;
            res.status = flags_q;
            expected_q.push_back(res);
        endfunction

        function void report(string what, exec_result_t want, exec_result_t got);
            mismatch_count++;
            if (mismatch_count <= 10)
            begin
                $display("%s: exp a=%h x=%h y=%h p=%h wb=%b sv=%h de=%b", what,
                         want.acc, want.x, want.y, want.status, want.write_back,
                         want.store_value, want.decimal_error);
                $display("%s: got a=%h x=%h y=%h p=%h wb=%b sv=%h de=%b", what,
                         got.acc, got.x, got.y, got.status, got.write_back,
                         got.store_value, got.decimal_error);
            end
        endfunction

        // Compare one returned result with the oldest prediction.
        function void check_result(exec_result_t got);
            exec_result_t want;
            if (expected_q.size() == 0)
            begin
                report("unexpected result", '0, got);
                return;
            end
            want = expected_q.pop_front();
            if (got.acc !== want.acc || got.x !== want.x || got.y !== want.y ||
                got.status !== want.status || got.write_back !== want.write_back ||
                got.store_value !== want.store_value ||
                got.decimal_error !== want.decimal_error)
            begin
                report("result mismatch", want, got);
            end
        endfunction

    endclass

endpackage

// ===== tb/sv/cpu8_alu_register_execute_top_tb.sv =====
// ============================================================================
// cpu8_alu_register_execute_top_tb
// Drives operation items into the execute stage, mirrors the register file
// and flags in a scoreboard class, and checks every result field in order
// under three back-pressure profiles.
// ============================================================================
module cpu8_alu_register_execute_top_tb;

    import cpu8_pkg::*;
    import cpu8_exec_mirror_pkg::*;

    // Top of the unused code space, treated by the block as a NOP.
    localparam logic [OP_W-1:0] OP_UNUSED_TOP = 6'd63;

    logic clk = 1'b0;
    logic rst_n;

    cpu8_req_if req_ch();
    cpu8_rsp_if rsp_ch();

    cpu8_alu_register_execute_top i_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    cpu8_exec_mirror mirror;

    // Idle odds in percent per cycle, changed per phase.
    int unsigned send_gap_pct;
    int unsigned recv_stall_pct;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Result side: check on every handshake, then pick the next ready level.
    // Values read here are the ones settled before the edge.
    always @(posedge clk)
    begin
        exec_result_t got;
        if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            got.acc           = rsp_ch.acc_out;
            got.x             = rsp_ch.x_out;
            got.y             = rsp_ch.y_out;
            got.status        = rsp_ch.status_out;
            got.write_back    = rsp_ch.write_back;
            got.store_value   = rsp_ch.store_value;
            got.decimal_error = rsp_ch.decimal_error;
            mirror.check_result(got);
        end
        rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Present one item, holding it until the block takes it, then tell the
    // mirror. Valid is only dropped when a gap is actually inserted.
    task automatic send_op(input logic [OP_W-1:0] code, input logic [BYTE_W-1:0] m,
                           input logic to_acc);
        while ($urandom_range(99) < send_gap_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid          <= 1'b1;
        req_ch.req_type       <= code;
        req_ch.operand        <= m;
        req_ch.to_accumulator <= to_acc;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        mirror.note_op(code, m, to_acc);
    endtask

    // Random item: mostly legal codes, extra weight on ADC and SBC, a few
    // unused codes, and operands biased toward the byte corners.
    task automatic send_random_op();
        logic [OP_W-1:0]   code;
        logic [BYTE_W-1:0] m;
        int unsigned       pick;
        pick = $urandom_range(99);
        if (pick < 6)
            code = OP_W'($urandom_range(OP_UNUSED_TOP, OP_NOP + 1));
        else if (pick < 18)
            code = $urandom_range(1) ? OP_ADC : OP_SBC;
        else
            code = OP_W'($urandom_range(OP_NOP, OP_ORA));
        case ($urandom_range(7))
            0:       m = 8'h00;
            1:       m = 8'hFF;
            2:       m = 8'h7F;
            3:       m = 8'h80;
            default: m = BYTE_W'($urandom_range(255));
        endcase
        send_op(code, m, 1'($urandom_range(1)));
    endtask

    // Directed opening: every operation at least once, arithmetic corners, decimal
    // refusal, shifts on both targets and an unused code.
    task automatic run_directed();
        send_op(OP_LDA, 8'hFF, 1'b1);   // negative load
        send_op(OP_LDX, 8'h00, 1'b0);   // zero load
        send_op(OP_LDY, 8'h80, 1'b1);
        send_op(OP_TSX, 8'h00, 1'b0);   // S still at reset value
        send_op(OP_LDX, 8'h7F, 1'b0);
        send_op(OP_TXS, 8'h00, 1'b1);   // copy X to S, flags untouched
        send_op(OP_TSX, 8'h00, 1'b0);
        send_op(OP_CLC, 8'h00, 1'b0);
        send_op(OP_ADC, 8'h01, 1'b0);   // FF + 1 wraps, carry out
        send_op(OP_ADC, 8'h7F, 1'b1);   // 00 + 7F + C, signed overflow
        send_op(OP_SBC, 8'hFF, 1'b0);
        send_op(OP_SEC, 8'h00, 1'b0);
        send_op(OP_SBC, 8'h01, 1'b0);
        send_op(OP_ORA, 8'h00, 1'b1);
        send_op(OP_AND, 8'hFF, 1'b0);
        send_op(OP_EOR, 8'hFF, 1'b1);
        send_op(OP_STA, 8'h5A, 1'b1);
        send_op(OP_STX, 8'hA5, 1'b0);
        send_op(OP_STY, 8'h00, 1'b0);
        send_op(OP_INC, 8'hFF, 1'b0);   // memory wraps to zero
        send_op(OP_DEC, 8'h00, 1'b1);   // memory wraps to FF
        send_op(OP_INX, 8'h00, 1'b0);
        send_op(OP_INY, 8'h00, 1'b0);
        send_op(OP_DEX, 8'h00, 1'b0);
        send_op(OP_DEY, 8'h00, 1'b0);
        send_op(OP_CMP, 8'h80, 1'b0);
        send_op(OP_CPX, 8'hFF, 1'b0);
        send_op(OP_CPY, 8'h00, 1'b1);
        send_op(OP_BIT, 8'hC0, 1'b0);
        send_op(OP_BIT, 8'h00, 1'b0);   // Z must be set by a zero mask
        send_op(OP_ASL, 8'h00, 1'b1);   // accumulator target, operand ignored
        send_op(OP_ASL, 8'h80, 1'b0);   // memory target, written back
        send_op(OP_LSR, 8'h01, 1'b0);
        send_op(OP_LSR, 8'hFF, 1'b1);
        send_op(OP_ROL, 8'h00, 1'b1);
        send_op(OP_ROR, 8'hFF, 1'b0);
        send_op(OP_TAX, 8'h00, 1'b0);
        send_op(OP_TAY, 8'h00, 1'b0);
        send_op(OP_TXA, 8'h00, 1'b0);
        send_op(OP_TYA, 8'h00, 1'b0);
        send_op(OP_SED, 8'h00, 1'b0);
        send_op(OP_ADC, 8'h55, 1'b0);   // refused in decimal mode
        send_op(OP_SBC, 8'hAA, 1'b1);   // refused in decimal mode
        send_op(OP_CLD, 8'h00, 1'b0);
        send_op(OP_SEI, 8'h00, 1'b0);
        send_op(OP_CLI, 8'h00, 1'b0);
        send_op(OP_CLV, 8'h00, 1'b0);
        send_op(OP_NOP, 8'hFF, 1'b1);
        send_op(OP_UNUSED_TOP, 8'hFF, 1'b1);
    endtask

    initial
    begin
        mirror                = new();
        rst_n                 = 1'b0;
        req_ch.valid          = 1'b0;
        req_ch.req_type       = OP_NOP;
        req_ch.operand        = '0;
        req_ch.to_accumulator = 1'b0;
        rsp_ch.ready          = 1'b0;
        send_gap_pct          = 6;
        recv_stall_pct        = 61;

        // Hold reset low from the start, then release it on an edge.
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Phase 1: sender mostly busy, receiver stalls often.
        run_directed();
        repeat (130) send_random_op();

        // Phase 2: swap the pressure.
        send_gap_pct   = 61;
        recv_stall_pct = 6;
        repeat (135) send_random_op();

        // Phase 3: full rate on both sides.
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        repeat (135) send_random_op();

        req_ch.valid <= 1'b0;

        // Drain outstanding results, then keep watching for strays.
        while (mirror.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mirror.mismatch_count == 0 && mirror.pending() == 0)
            $display("cpu8_alu_register_execute_top_tb OK");
        else
            $display("cpu8_alu_register_execute_top_tb NOT OK");
        $finish;
    end

    // Watchdog: far beyond the slowest legitimate run.
    initial
    begin
        #4000000;
        $display("cpu8_alu_register_execute_top_tb NOT OK");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/cpu8_pkg.sv
hdl/cpu8_req_if.sv
hdl/cpu8_rsp_if.sv
hdl/cpu8_alu_register_execute_top.sv
tb/sv/cpu8_exec_mirror_pkg.sv
tb/sv/cpu8_alu_register_execute_top_tb.sv
